@@ hw/rtl/fldot_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package fldot_pkg;

  localparam int FMA_STAGES = 7;
  localparam int FMA_UNITS  = 5;
  localparam int PIPE_DEPTH = FMA_UNITS * FMA_STAGES + 1;

  localparam logic [31:0] EXP_MASK    = 32'h7f80_0000;
  localparam logic [31:0] ABS_MASK    = 32'h7fff_ffff;
  localparam logic [31:0] SIGN_BIT    = 32'h8000_0000;
  localparam logic [31:0] QUIET_BIT   = 32'h0040_0000;
  localparam logic [31:0] DEFAULT_NAN = 32'hffc0_0000;
  localparam logic [31:0] ONE_F       = 32'h3f80_0000;
  localparam logic [31:0] INT_INVALID = 32'h8000_0000;

  localparam logic [1:0] REG_LIGHT_X = 2'd0;
  localparam logic [1:0] REG_LIGHT_Y = 2'd1;
  localparam logic [1:0] REG_LIGHT_Z = 2'd2;
  localparam logic [1:0] REG_SCALE   = 2'd3;

  typedef logic signed [11:0] exp_t;

  typedef struct packed {
    logic [31:0] ny;
    logic [31:0] nz;
    logic        last;
  } side_t;

  function automatic logic [31:0] flush_sub(input logic [31:0] x);
    return ((x & EXP_MASK) == 32'd0) ? (x & SIGN_BIT) : x;
  endfunction

  function automatic logic is_nan(input logic [31:0] x);
    return (x & ABS_MASK) > EXP_MASK;
  endfunction

  function automatic logic is_inf(input logic [31:0] x);
    return (x & ABS_MASK) == EXP_MASK;
  endfunction

  function automatic logic is_zero(input logic [31:0] x);
    return (x & ABS_MASK) == 32'd0;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/fldot_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface fldot_normal_if;
  logic        valid;
  logic        ready;
  logic [31:0] normal_x;
  logic [31:0] normal_y;
  logic [31:0] normal_z;
  logic        last_normal;

  modport source (output valid, normal_x, normal_y, normal_z, last_normal, input ready);
  modport sink (input valid, normal_x, normal_y, normal_z, last_normal, output ready);
endinterface

interface fldot_result_if;
  logic               valid;
  logic               ready;
  logic        [31:0] scaled_value;
  logic signed [31:0] integer_value;
  logic               last_result;

  modport source (output valid, scaled_value, integer_value, last_result, input ready);
  modport sink (input valid, scaled_value, integer_value, last_result, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/fldot_fma.sv @@
`timescale 1ns / 1ps
`default_nettype none

module fldot_fma (
  input  logic                                clk,
  input  logic [fldot_pkg::FMA_STAGES-1:0]    en,
  input  logic [31:0]                         a,
  input  logic [31:0]                         b,
  input  logic [31:0]                         c,
  output logic [31:0]                         res
);

  function automatic logic [5:0] top_pos(input logic [63:0] x);
    logic [5:0] p;
    p = '0;
    for (int i = 0; i < 64; i++) begin
      if (x[i]) p = 6'(i);
    end
    return p;
  endfunction

  function automatic logic [23:0] mant(input logic [31:0] x);
    return (x[30:23] == 8'd0) ? {1'b0, x[22:0]} : {1'b1, x[22:0]};
  endfunction

  function automatic fldot_pkg::exp_t expo(input logic [31:0] x);
    return (x[30:23] == 8'd0) ? fldot_pkg::exp_t'(-149)
                              : fldot_pkg::exp_t'({4'b0, x[30:23]}) - fldot_pkg::exp_t'(150);
  endfunction

  // stage 1: specials, unpack, multiply
  logic        sp1, sc1, spec1;
  logic [31:0] sval1;
  logic [47:0] mp1;

  logic              s1_spec, s1_sp, s1_sc, s1_cz;
  logic [31:0]       s1_sval;
  logic [47:0]       s1_mp;
  logic [23:0]       s1_mc;
  fldot_pkg::exp_t   s1_ep, s1_ec;

  always_comb begin
    sp1   = a[31] ^ b[31];
    sc1   = c[31];
    spec1 = 1'b1;
    sval1 = '0;
    if (fldot_pkg::is_nan(a)) begin
      sval1 = a | fldot_pkg::QUIET_BIT;
    end else if (fldot_pkg::is_nan(b)) begin
      sval1 = b | fldot_pkg::QUIET_BIT;
    end else if (fldot_pkg::is_nan(c)) begin
      sval1 = c | fldot_pkg::QUIET_BIT;
    end else if ((fldot_pkg::is_inf(a) && fldot_pkg::is_zero(b)) ||
                 (fldot_pkg::is_zero(a) && fldot_pkg::is_inf(b))) begin
      sval1 = fldot_pkg::DEFAULT_NAN;
    end else if (fldot_pkg::is_inf(a) || fldot_pkg::is_inf(b)) begin
      sval1 = (fldot_pkg::is_inf(c) && (sc1 != sp1)) ? fldot_pkg::DEFAULT_NAN
                                                     : {sp1, 31'h7f80_0000};
    end else if (fldot_pkg::is_inf(c)) begin
      sval1 = c;
    end else if (fldot_pkg::is_zero(a) || fldot_pkg::is_zero(b)) begin
      sval1 = fldot_pkg::is_zero(c) ? {sp1 & sc1, 31'd0} : c;
    end else begin
      spec1 = 1'b0;
    end
  end

  assign mp1 = 48'(mant(a)) * 48'(mant(b));

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_spec <= spec1;
      s1_sval <= sval1;
      s1_sp   <= sp1;
      s1_sc   <= sc1;
      s1_cz   <= fldot_pkg::is_zero(c);
      s1_mp   <= mp1;
      s1_ep   <= expo(a) + expo(b);
      s1_mc   <= mant(c);
      s1_ec   <= expo(c);
    end
  end

  // stage 2: normalize product and addend
  logic [5:0] lzp2, lzc2;

  logic              s2_spec, s2_sp, s2_sc, s2_cz;
  logic [31:0]       s2_sval;
  logic [61:0]       s2_x, s2_y;
  fldot_pkg::exp_t   s2_ex, s2_ey;

  assign lzp2 = 6'd61 - top_pos({16'd0, s1_mp});
  assign lzc2 = 6'd61 - top_pos({40'd0, s1_mc});

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s2_spec <= s1_spec;
      s2_sval <= s1_sval;
      s2_sp   <= s1_sp;
      s2_sc   <= s1_sc;
      s2_cz   <= s1_cz;
      s2_x    <= 62'(s1_mp) << lzp2;
      s2_ex   <= s1_ep - fldot_pkg::exp_t'(lzp2);
      s2_y    <= 62'(s1_mc) << lzc2;
      s2_ey   <= s1_ec - fldot_pkg::exp_t'(lzc2);
    end
  end

  // stage 3: order and align
  logic [61:0]     bx3, ys3, sm3;
  logic            bsx3, bsy3;
  fldot_pkg::exp_t be3, d3;

  logic              s3_spec, s3_sx, s3_sy;
  logic [31:0]       s3_sval;
  logic [61:0]       s3_x, s3_y;
  fldot_pkg::exp_t   s3_e;

  always_comb begin
    bx3  = s2_x;
    be3  = s2_ex;
    bsx3 = s2_sp;
    ys3  = s2_y;
    bsy3 = s2_sc;
    d3   = s2_ex - s2_ey;
    if (s2_cz) begin
      ys3  = '0;
      bsy3 = s2_sp;
      d3   = '0;
    end else if (s2_ex < s2_ey) begin
      bx3  = s2_y;
      be3  = s2_ey;
      bsx3 = s2_sc;
      ys3  = s2_x;
      bsy3 = s2_sp;
      d3   = s2_ey - s2_ex;
    end
    if (s2_cz) begin
      sm3 = '0;
    end else if (d3 >= fldot_pkg::exp_t'(63)) begin
      sm3 = 62'd1;
    end else if (d3 > fldot_pkg::exp_t'(0)) begin
      sm3 = (ys3 >> d3[5:0]) |
            62'(|(ys3 & ((62'd1 << d3[5:0]) - 62'd1)));
    end else begin
      sm3 = ys3;
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s3_spec <= s2_spec;
      s3_sval <= s2_sval;
      s3_x    <= bx3;
      s3_y    <= sm3;
      s3_e    <= be3;
      s3_sx   <= bsx3;
      s3_sy   <= bsy3;
    end
  end

  // stage 4: add or subtract magnitudes
  logic [62:0] r4;
  logic        sr4;

  logic              s4_spec, s4_sr;
  logic [31:0]       s4_sval;
  logic [62:0]       s4_r;
  fldot_pkg::exp_t   s4_e;

  always_comb begin
    if (s3_sx == s3_sy) begin
      r4  = {1'b0, s3_x} + {1'b0, s3_y};
      sr4 = s3_sx;
    end else if (s3_x >= s3_y) begin
      r4  = {1'b0, s3_x - s3_y};
      sr4 = s3_sx;
    end else begin
      r4  = {1'b0, s3_y - s3_x};
      sr4 = s3_sy;
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s4_spec <= s3_spec;
      s4_sval <= s3_sval;
      s4_r    <= r4;
      s4_sr   <= sr4;
      s4_e    <= s3_e;
    end
  end

  // stage 5: find rounding position
  fldot_pkg::exp_t sh5, lo5;
  logic            zero5;

  logic              s5_spec, s5_sr;
  logic [31:0]       s5_sval;
  logic [62:0]       s5_r;
  fldot_pkg::exp_t   s5_e, s5_s;

  always_comb begin
    zero5 = (s4_r == 63'd0);
    sh5   = fldot_pkg::exp_t'(top_pos({1'b0, s4_r})) - fldot_pkg::exp_t'(23);
    lo5   = fldot_pkg::exp_t'(-149) - s4_e;
    if (sh5 < lo5) sh5 = lo5;
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s5_spec <= s4_spec | zero5;
      s5_sval <= s4_spec ? s4_sval : 32'd0;
      s5_sr   <= s4_sr;
      s5_r    <= s4_r;
      s5_e    <= s4_e;
      s5_s    <= sh5;
    end
  end

  // stage 6: shift and round to nearest even
  logic [24:0]     q6;
  logic [62:0]     shr6, mask6;
  logic [5:0]      sa6;
  fldot_pkg::exp_t neg6;
  logic            guard6, sticky6;

  logic              s6_spec, s6_sr;
  logic [31:0]       s6_sval;
  logic [24:0]       s6_q;
  fldot_pkg::exp_t   s6_es;

  always_comb begin
    neg6    = -s5_s;
    sa6     = s5_s[5:0];
    shr6    = s5_r >> sa6;
    mask6   = (63'd1 << (sa6 - 6'd1)) - 63'd1;
    guard6  = 1'b0;
    sticky6 = 1'b0;
    if (s5_s <= fldot_pkg::exp_t'(0)) begin
      q6 = {1'b0, s5_r[23:0] << neg6[4:0]};
    end else if (s5_s >= fldot_pkg::exp_t'(64)) begin
      q6 = '0;
    end else begin
      q6      = {1'b0, shr6[23:0]};
      guard6  = s5_r[sa6 - 6'd1];
      sticky6 = |(s5_r & mask6);
      if (guard6 && (sticky6 || q6[0])) q6 = q6 + 25'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s6_spec <= s5_spec;
      s6_sval <= s5_sval;
      s6_sr   <= s5_sr;
      s6_q    <= q6;
      s6_es   <= s5_e + s5_s;
    end
  end

  // stage 7: renormalize and pack
  logic [24:0]     q7;
  fldot_pkg::exp_t es7, bexp7;
  logic [31:0]     pk7;

  always_comb begin
    q7  = s6_q;
    es7 = s6_es;
    if (q7[24]) begin
      q7  = q7 >> 1;
      es7 = es7 + fldot_pkg::exp_t'(1);
    end
    bexp7 = es7 + fldot_pkg::exp_t'(150);
    if (s6_q == 25'd0) begin
      pk7 = {s6_sr, 31'd0};
    end else if (!q7[23]) begin
      pk7 = {s6_sr, 8'd0, q7[22:0]};
    end else if (bexp7 >= fldot_pkg::exp_t'(255)) begin
      pk7 = {s6_sr, 31'h7f80_0000};
    end else begin
      pk7 = {s6_sr, bexp7[7:0], q7[22:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      res <= s6_spec ? s6_sval : pk7;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/fipr_light_dot_scale.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Lights a stream of surface normals against a programmed light vector and
// scales the result: dot = lx*nx + ly*ny + lz*nz through chained fused
// multiply-adds (round to nearest even, subnormals flushed on the vector
// components and on the dot), then scaled_value = dot*scale + scale and its
// int32 truncation (0x80000000 when NaN or out of range). One request is
// taken per clock unless a stall backs up to the first stage; each passes
// through five seven-stage multiply-add units and then the output register.
// Stalls on the result side back up only as far as the first empty stage.
// Program the four registers only while no request is in flight.
module fipr_light_dot_scale (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [1:0]            cfg_index,
  input  logic [31:0]           cfg_data,
  fldot_normal_if.sink          normal,
  fldot_result_if.source        result
);

  localparam int FS = fldot_pkg::FMA_STAGES;
  localparam int PD = fldot_pkg::PIPE_DEPTH;

  function automatic logic [31:0] trunc_int(input logic [31:0] v);
    logic [31:0] m;
    logic [31:0] mag;
    logic [7:0]  k;
    m   = {8'd0, 1'b1, v[22:0]};
    k   = v[30:23] - 8'd127;
    mag = '0;
    if (v[30:23] == 8'hff) return fldot_pkg::INT_INVALID;
    if (v[30:23] < 8'd127) return 32'd0;
    if (k >= 8'd31) return fldot_pkg::INT_INVALID;
    mag = (k >= 8'd23) ? (m << (k - 8'd23)) : (m >> (8'd23 - k));
    return v[31] ? (32'd0 - mag) : mag;
  endfunction

  logic [31:0] light_x, light_y, light_z, scale_factor;

  always_ff @(posedge clk) begin
    if (rst) begin
      light_x      <= '0;
      light_y      <= '0;
      light_z      <= '0;
      scale_factor <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        fldot_pkg::REG_LIGHT_X: light_x      <= cfg_data;
        fldot_pkg::REG_LIGHT_Y: light_y      <= cfg_data;
        fldot_pkg::REG_LIGHT_Z: light_z      <= cfg_data;
        fldot_pkg::REG_SCALE:   scale_factor <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [PD-1:0] valid;
  logic [PD-1:0] en;

  // advance a stage when the output drains or a bubble sits at or past it
  always_comb begin
    for (int k = 0; k < PD; k++) begin
      en[k] = result.ready || (((~valid) >> k) != '0);
    end
  end

  assign normal.ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (en[0]) valid[0] <= normal.valid;
      for (int k = 1; k < PD; k++) begin
        if (en[k]) valid[k] <= valid[k-1];
      end
    end
  end

  fldot_pkg::side_t side [PD-1];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      side[0] <= '{ny: normal.normal_y, nz: normal.normal_z, last: normal.last_normal};
    end
    for (int k = 1; k < PD - 1; k++) begin
      if (en[k]) side[k] <= side[k-1];
    end
  end

  logic [31:0] dot1, dot2, dot3, dot_fix, prod, value;

  fldot_fma u_fma_x (
    .clk (clk),
    .en  (en[0*FS +: FS]),
    .a   (fldot_pkg::flush_sub(light_x)),
    .b   (fldot_pkg::flush_sub(normal.normal_x)),
    .c   (fldot_pkg::SIGN_BIT),
    .res (dot1)
  );

  fldot_fma u_fma_y (
    .clk (clk),
    .en  (en[1*FS +: FS]),
    .a   (fldot_pkg::flush_sub(light_y)),
    .b   (fldot_pkg::flush_sub(side[FS-1].ny)),
    .c   (dot1),
    .res (dot2)
  );

  fldot_fma u_fma_z (
    .clk (clk),
    .en  (en[2*FS +: FS]),
    .a   (fldot_pkg::flush_sub(light_z)),
    .b   (fldot_pkg::flush_sub(side[2*FS-1].nz)),
    .c   (dot2),
    .res (dot3)
  );

  // quiet NaN, drop negative zero, flush subnormal
  always_comb begin
    if (fldot_pkg::is_nan(dot3)) begin
      dot_fix = dot3 | fldot_pkg::QUIET_BIT;
    end else if (fldot_pkg::is_zero(dot3)) begin
      dot_fix = '0;
    end else begin
      dot_fix = fldot_pkg::flush_sub(dot3);
    end
  end

  fldot_fma u_fma_scale (
    .clk (clk),
    .en  (en[3*FS +: FS]),
    .a   (dot_fix),
    .b   (scale_factor),
    .c   (fldot_pkg::SIGN_BIT),
    .res (prod)
  );

  fldot_fma u_fma_offset (
    .clk (clk),
    .en  (en[4*FS +: FS]),
    .a   (prod),
    .b   (fldot_pkg::ONE_F),
    .c   (scale_factor),
    .res (value)
  );

  assign result.valid = valid[PD-1];

  always_ff @(posedge clk) begin
    if (en[PD-1]) begin
      result.scaled_value  <= value;
      result.integer_value <= signed'(trunc_int(value));
      result.last_result   <= side[PD-2].last;
    end
  end

  a_reset_clears: assert property (@(posedge clk) rst |=> (valid == '0))
    else $error("pipeline valid bits not cleared by reset");

  a_full_stalls: assert property (@(posedge clk) disable iff (rst)
    ((&valid) && !result.ready) |-> !normal.ready)
    else $error("request taken while pipeline full and stalled");

  a_load: assert property (@(posedge clk) disable iff (rst)
    (normal.valid && normal.ready) |=> valid[0])
    else $error("accepted request lost at first stage");

  a_hold_mid: assert property (@(posedge clk) disable iff (rst)
    (valid[3*FS-1] && !en[3*FS-1]) |=> valid[3*FS-1])
    else $error("stalled stage dropped its item");

  a_small_int: assert property (@(posedge clk) disable iff (rst)
    (result.valid && (result.scaled_value[30:23] < 8'd127))
      |-> (result.integer_value == 32'sd0))
    else $error("magnitude below one gave nonzero integer");

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

  logic clk;
  logic rst;
  logic cfg_write;
  logic [1:0] cfg_index;
  logic [31:0] cfg_data;

  fldot_normal_if normal ();
  fldot_result_if result ();

  fipr_light_dot_scale dut (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .normal(normal.sink), .result(result.source)
  );

  typedef struct {
    logic [31:0] scaled;
    logic [31:0] ival;
    logic        last;
  } lit_t;

  typedef struct {
    logic [31:0] nx;
    logic [31:0] ny;
    logic [31:0] nz;
    logic        last;
    logic        known;
    logic [31:0] scaled;
    logic [31:0] ival;
  } row_t;

  logic [31:0] lx_q, ly_q, lz_q, scale_q;
  lit_t lit_q[$];
  int errors = 0;
  int checked = 0;
  longint cycles = 0;
  int send_idle = 0;
  int recv_stall = 0;
  bit hold_off = 0;

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("timeout at %0t", $time);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic int top_of(logic [63:0] x);
    int p;
    p = -1;
    for (int i = 0; i < 64; i++) if (x[i]) p = i;
    return p;
  endfunction

  function automatic logic [31:0] fz(logic [31:0] x);
    return (x[30:23] == 8'd0) ? {x[31], 31'd0} : x;
  endfunction

  function automatic bit nan_of(logic [31:0] x);
    return x[30:0] > 31'h7f80_0000;
  endfunction

  function automatic bit inf_of(logic [31:0] x);
    return x[30:0] == 31'h7f80_0000;
  endfunction

  function automatic bit zero_of(logic [31:0] x);
    return x[30:0] == 31'd0;
  endfunction

  function automatic logic [31:0] pack_round(logic [31:0] sg, logic [63:0] r, int e);
    int t, s, es;
    logic [63:0] q, rem, half;
    t = top_of(r);
    s = t - 23;
    if (s < -149 - e) s = -149 - e;
    if (s <= 0) q = r << (-s);
    else if (s >= 65) q = 0;
    else begin
      if (s == 64) begin
        r = (r >> 1) | (r & 64'd1);
        s = 63;
      end
      q = r >> s;
      rem = r & ((64'd1 << s) - 1);
      half = 64'd1 << (s - 1);
      if (rem > half || (rem == half && q[0])) q++;
    end
    es = e + s;
    if (q == 0) return sg;
    if (q >= (64'd1 << 24)) begin
      q >>= 1;
      es++;
    end
    if (q < (64'd1 << 23)) return sg | q[31:0];
    if (es + 150 >= 255) return sg | fldot_pkg::EXP_MASK;
    return sg | (32'(es + 150) << 23) | {9'd0, q[22:0]};
  endfunction

  function automatic void split(logic [31:0] x, output logic [63:0] m, output int e);
    if (x[30:23] == 0) begin
      m = {41'd0, x[22:0]};
      e = -149;
    end else begin
      m = {40'd0, 1'b1, x[22:0]};
      e = int'(x[30:23]) - 150;
    end
  endfunction

  function automatic logic [31:0] mul_add(logic [31:0] a, logic [31:0] b, logic [31:0] c);
    logic [31:0] sp, sc, sx, sy, sr;
    logic [63:0] ma, mb, mc, mp, x, y, r;
    int ea, eb, ec, ep, ex, d, lzc;
    sp = (a ^ b) & fldot_pkg::SIGN_BIT;
    sc = c & fldot_pkg::SIGN_BIT;
    if (nan_of(a)) return a | fldot_pkg::QUIET_BIT;
    if (nan_of(b)) return b | fldot_pkg::QUIET_BIT;
    if (nan_of(c)) return c | fldot_pkg::QUIET_BIT;
    if ((inf_of(a) && zero_of(b)) || (zero_of(a) && inf_of(b))) return fldot_pkg::DEFAULT_NAN;
    if (inf_of(a) || inf_of(b)) begin
      if (inf_of(c) && sc != sp) return fldot_pkg::DEFAULT_NAN;
      return sp | fldot_pkg::EXP_MASK;
    end
    if (inf_of(c)) return c;
    if (zero_of(a) || zero_of(b)) begin
      if (zero_of(c)) return sp & sc;
      return c;
    end
    split(a, ma, ea);
    split(b, mb, eb);
    mp = ma * mb;
    ep = ea + eb;
    if (zero_of(c)) return pack_round(sp, mp, ep);
    split(c, mc, ec);
    lzc = 61 - top_of(mp); mp <<= lzc; ep -= lzc;
    lzc = 61 - top_of(mc); mc <<= lzc; ec -= lzc;
    if (ep >= ec) begin
      x = mp; ex = ep; sx = sp; y = mc; sy = sc; d = ep - ec;
    end else begin
      x = mc; ex = ec; sx = sc; y = mp; sy = sp; d = ec - ep;
    end
    if (d >= 63) y = 1;
    else if (d > 0) y = (y >> d) | ((y & ((64'd1 << d) - 1)) != 0);
    if (sx == sy) begin
      r = x + y; sr = sx;
    end else if (x >= y) begin
      r = x - y; sr = sx;
    end else begin
      r = y - x; sr = sy;
    end
    if (r == 0) return 32'd0;
    return pack_round(sr, r, ex);
  endfunction

  function automatic logic [31:0] to_int(logic [31:0] v);
    logic [31:0] m, mag;
    int k;
    m = {9'd1, v[22:0]};
    if (v[30:23] == 8'hff) return fldot_pkg::INT_INVALID;
    if (v[30:23] < 8'd127) return 32'd0;
    k = int'(v[30:23]) - 127;
    if (k >= 31) return fldot_pkg::INT_INVALID;
    mag = (k >= 23) ? (m << (k - 23)) : (m >> (23 - k));
    return v[31] ? -mag : mag;
  endfunction

  function automatic lit_t light_normal(logic [31:0] nx, logic [31:0] ny,
                                        logic [31:0] nz, logic last);
    lit_t o;
    logic [31:0] dot, prod;
    dot = mul_add(fz(lx_q), fz(nx), fldot_pkg::SIGN_BIT);
    dot = mul_add(fz(ly_q), fz(ny), dot);
    dot = mul_add(fz(lz_q), fz(nz), dot);
    dot = fz(mul_add(32'd0, fldot_pkg::ONE_F, dot));
    prod = mul_add(dot, scale_q, fldot_pkg::SIGN_BIT);
    o.scaled = mul_add(prod, fldot_pkg::ONE_F, scale_q);
    o.ival = to_int(o.scaled);
    o.last = last;
    return o;
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
    case (idx)
      fldot_pkg::REG_LIGHT_X: lx_q = val;
      fldot_pkg::REG_LIGHT_Y: ly_q = val;
      fldot_pkg::REG_LIGHT_Z: lz_q = val;
      default: scale_q = val;
    endcase
  endtask

  task automatic program_light(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                               logic [31:0] s);
    normal.valid <= 1'b0;
    while (lit_q.size() != 0) @(posedge clk);
    repeat (45) @(posedge clk);
    write_reg(fldot_pkg::REG_LIGHT_X, x);
    write_reg(fldot_pkg::REG_LIGHT_Y, y);
    write_reg(fldot_pkg::REG_LIGHT_Z, z);
    write_reg(fldot_pkg::REG_SCALE, s);
  endtask

  task automatic send_normal(row_t r);
    lit_t p;
    while ($urandom_range(99) < send_idle) begin
      normal.valid <= 1'b0;
      @(negedge clk);
    end
    normal.valid <= 1'b1;
    normal.normal_x <= r.nx;
    normal.normal_y <= r.ny;
    normal.normal_z <= r.nz;
    normal.last_normal <= r.last;
    @(posedge clk);
    while (!normal.ready) @(posedge clk);
    p = light_normal(r.nx, r.ny, r.nz, r.last);
    if (r.known) begin
      p.scaled = r.scaled;
      p.ival = r.ival;
    end
    lit_q.push_back(p);
    @(negedge clk);
  endtask

  function automatic logic [31:0] rand_float();
    case ($urandom_range(9))
      0: return $urandom();
      1: return {1'($urandom_range(1)), 8'd0, 23'($urandom())};
      2: return {1'($urandom_range(1)), 8'hff,
                 ($urandom_range(3) == 0) ? 23'd0 : 23'($urandom())};
      3: return {1'($urandom_range(1)), 31'd0};
      4: return {1'($urandom_range(1)), 8'($urandom_range(150, 160)), 23'($urandom())};
      default: return {1'($urandom_range(1)), 8'($urandom_range(118, 130)), 23'($urandom())};
    endcase
  endfunction

  always @(negedge clk) begin
    if (rst) result.ready <= 1'b0;
    else result.ready <= !hold_off && ($urandom_range(99) >= recv_stall);
  end

  always @(posedge clk) begin
    lit_t e;
    if (!rst && result.valid && result.ready) begin
      if (lit_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, result.scaled_value);
        errors++;
      end else begin
        e = lit_q.pop_front();
        checked++;
        if (result.scaled_value !== e.scaled || result.integer_value !== e.ival ||
            result.last_result !== e.last) begin
          $display("%0t: expected %h %h %b actual %h %h %b", $time, e.scaled, e.ival,
                   e.last, result.scaled_value, result.integer_value, result.last_result);
          errors++;
        end
      end
    end
  end

  row_t plan[$];
  row_t r;

  function automatic row_t mk(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic l);
    row_t t;
    t.nx = x; t.ny = y; t.nz = z; t.last = l; t.known = 1'b0;
    t.scaled = 0; t.ival = 0;
    return t;
  endfunction

  function automatic row_t mkk(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic l,
                               logic [31:0] s, logic [31:0] iv);
    row_t t;
    t = mk(x, y, z, l);
    t.known = 1'b1; t.scaled = s; t.ival = iv;
    return t;
  endfunction

  initial begin
    rst = 1;
    cfg_write = 1'b0; cfg_index = 2'd0; cfg_data = 32'd0;
    normal.valid = 1'b0; normal.normal_x = 32'd0; normal.normal_y = 32'd0;
    normal.normal_z = 32'd0; normal.last_normal = 1'b0;
    lx_q = 0; ly_q = 0; lz_q = 0; scale_q = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // after reset the light and scale registers are zero
    send_normal(mkk(32'h3f80_0000, 32'hffff_ffff, 32'h7f80_0000, 1'b1, 32'hffff_ffff,
                    fldot_pkg::INT_INVALID));
    send_normal(mkk(32'h0, 32'h0, 32'h0, 1'b0, 32'h0, 32'h0));

    program_light(fldot_pkg::ONE_F, 32'h4000_0000, 32'hbf80_0000, fldot_pkg::ONE_F);
    plan = {};
    plan.push_back(mkk(32'h0, 32'h0, 32'h0, 1'b1, fldot_pkg::ONE_F, 32'd1));
    plan.push_back(mkk(32'h8000_0000, 32'h8000_0000, 32'h0, 1'b0, fldot_pkg::ONE_F, 32'd1));
    plan.push_back(mkk(32'h0000_0001, 32'h807f_ffff, 32'h0, 1'b0, fldot_pkg::ONE_F, 32'd1));
    plan.push_back(mkk(fldot_pkg::ONE_F, 32'h0, 32'h0, 1'b1, 32'h4000_0000, 32'd2));
    plan.push_back(mkk(32'h7fc0_0000, 32'h0, 32'h0, 1'b0, 32'h7fc0_0000,
                       fldot_pkg::INT_INVALID));
    plan.push_back(mkk(32'h7f80_0000, 32'h0, 32'h7f80_0000, 1'b0, fldot_pkg::DEFAULT_NAN,
                       fldot_pkg::INT_INVALID));
    plan.push_back(mkk(32'h7f80_0000, 32'h0, 32'h0, 1'b1, 32'h7f80_0000,
                       fldot_pkg::INT_INVALID));
    plan.push_back(mkk(32'hff80_0000, 32'h0, 32'h0, 1'b0, 32'hff80_0000,
                       fldot_pkg::INT_INVALID));
    plan.push_back(mk(32'h7f7f_ffff, 32'h7f7f_ffff, 32'h0, 1'b0));
    plan.push_back(mk(32'hff7f_ffff, 32'h0, 32'h7f7f_ffff, 1'b1));
    plan.push_back(mk(32'h7f80_0001, 32'hffc0_0001, 32'h0, 1'b0));
    plan.push_back(mk(32'h3f00_0000, 32'h3e80_0000, 32'h3f80_0000, 1'b0));
    plan.push_back(mk(32'h0080_0000, 32'h0, 32'h0, 1'b0));
    plan.push_back(mk(32'h4f00_0000, 32'h0, 32'h0, 1'b1));
    plan.push_back(mk(32'hcf00_0000, 32'h0, 32'h0, 1'b0));
    plan.push_back(mk(32'hbf80_0000, 32'h0, 32'h0, 1'b0));
    foreach (plan[i]) send_normal(plan[i]);

    program_light(32'h007f_ffff, 32'h7f7f_ffff, 32'h8000_0001, 32'h0000_0001);
    send_normal(mk(32'hffff_ffff, 32'h3f80_0000, 32'hbf80_0000, 1'b1));
    send_normal(mk(32'h0, 32'h4000_0000, 32'h0, 1'b0));
    program_light(32'hffff_ffff, 32'h0, 32'h0, 32'hffff_ffff);
    send_normal(mk(32'h0, 32'h0, 32'h0, 1'b0));
    send_normal(mk(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1'b1));

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle = 0; recv_stall = 0; end
        1: begin send_idle = 58; recv_stall = 0; end
        2: begin send_idle = 0; recv_stall = 58; end
        default: begin send_idle = 7; recv_stall = 7; end
      endcase
      program_light(rand_float(), rand_float(), rand_float(),
                    ($urandom_range(3) == 0) ? rand_float() : 32'h3f80_0000);
      if (ph == 4) begin
        fork
          begin
            hold_off = 1;
            repeat (150) @(posedge clk);
            hold_off = 0;
          end
        join_none
      end
      for (int k = 0; k < 137; k++) begin
        r = mk(rand_float(), rand_float(), rand_float(), 1'($urandom_range(1)));
        send_normal(r);
      end
    end

    normal.valid <= 1'b0;
    while (lit_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("covered %0d results over directed extremes and eight random light setups",
             checked);
    $display("phases mixed sender gaps, receiver stalls and one long output hold-off");
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end
endmodule
